// ===== src/nosc_pkg.sv =====
// Shared types, constants and byte-class helper for the natural-order string comparator.
package nosc_pkg;

    // Default store depth in bytes for each string.
    localparam int MAX_LEN_DEF = 64;

    // Saturating decimal value of a digit run.
    localparam int           VALUE_W   = 32;
    localparam logic [31:0]  VALUE_CAP = 32'hFFFF_FFFF;

    // Byte classes, in ascending order.
    typedef logic [1:0] cls_t;
    localparam cls_t CLS_END    = 2'd0;
    localparam cls_t CLS_DIGIT  = 2'd1;
    localparam cls_t CLS_LETTER = 2'd2;
    localparam cls_t CLS_OTHER  = 2'd3;

    // Result codes (signed two-bit).
    localparam logic [1:0] ORD_LESS    = 2'b11;
    localparam logic [1:0] ORD_EQUAL   = 2'b00;
    localparam logic [1:0] ORD_GREATER = 2'b01;

    // Input action codes.
    localparam logic ACT_FIRST  = 1'b0;
    localparam logic ACT_SECOND = 1'b1;

    // Control from the loader to the compare walk.
    typedef struct packed {
        logic start;    // both strings ended, begin the compare
        logic take;     // result moved into the output register
    } walk_ctrl_t;

    // Status from the compare walk to the loader.
    typedef struct packed {
        logic busy;     // a compare is in flight or its result is pending
        logic done;     // result is ready
    } walk_stat_t;

    // Class of one byte.
    function automatic cls_t class_of(input logic [7:0] b);
        cls_t c;
        if (b == 8'h00) begin
            c = CLS_END;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            c = CLS_DIGIT;
        end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
            c = CLS_LETTER;
        end else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

// ===== src/natural_order_string_compare_core.sv =====
// Natural-order string comparator: loads two zero-ended strings, returns their order.
//
// Bytes of either string are taken one per cycle while in_stall is low and stored (up
// to MAX_LEN non-zero bytes each; extra bytes are dropped and reported in truncated).
// The transaction carrying the zero byte that ends the second of the two strings starts
// the compare; in_stall is then high until the result has moved into the output
// register. The compare walk reads both stores through registered RAM ports; it fetches
// and then evaluates each byte position in letter and other runs, reads a digit run
// digit by digit in the first string and then in the second through the shared
// saturating x10 accumulator before comparing the two values, closes with an end
// check, and hands off the result when the output register is free or not stalled.
// Bytes for a string that has already ended are ignored. The output register lets the
// next pair load while a result waits.
module natural_order_string_compare_core
    import nosc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [7:0]        char_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [1:0] order,
    output logic              truncated
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int PW = $clog2(MAX_LEN+1);

    logic [PW-1:0] len_a_reg, len_a_next, len_b_reg, len_b_next;
    logic [1:0]    ended_reg, ended_next;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    order_reg;
    logic          trunc_reg;

    logic          in_acc;
    logic          live;
    logic [1:0]    act_bit;
    logic          we_a, we_b;
    logic          load_out;
    walk_ctrl_t    ctrl;
    walk_stat_t    stat;
    logic [AW-1:0] raddr_a, raddr_b;
    logic [7:0]    rdata_a, rdata_b;
    logic [1:0]    res_order;
    logic          res_trunc;

    assign in_stall = stat.busy;
    assign in_acc   = in_valid && !in_stall;
    assign act_bit  = (action == ACT_SECOND) ? 2'b10 : 2'b01;
    assign live     = in_acc && ((ended_reg & act_bit) == 2'b00);

    // Store writes for non-zero bytes with room left
    assign we_a = live && (action == ACT_FIRST) && (char_byte != 8'h00)
                  && (len_a_reg < PW'(MAX_LEN));
    assign we_b = live && (action == ACT_SECOND) && (char_byte != 8'h00)
                  && (len_b_reg < PW'(MAX_LEN));

    // Load bookkeeping; the pair clears as its compare starts
    always_comb
    begin
        len_a_next = len_a_reg;
        len_b_next = len_b_reg;
        ended_next = ended_reg;
        ovf_next   = ovf_reg;
        ctrl.start = 1'b0;
        ctrl.take  = load_out;
        if (live)
        begin
            if (char_byte == 8'h00)
            begin
                if ((ended_reg | act_bit) == 2'b11)
                begin
                    ctrl.start = 1'b1;
                    len_a_next = '0;
                    len_b_next = '0;
                    ended_next = 2'b00;
                    ovf_next   = 1'b0;
                end
                else
                begin
                    ended_next = ended_reg | act_bit;
                end
            end
            else if (we_a)
            begin
                len_a_next = len_a_reg + 1'b1;
            end
            else if (we_b)
            begin
                len_b_next = len_b_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // Output register handoff
    assign load_out  = stat.done && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            ended_reg     <= 2'b00;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_a_reg     <= len_a_next;
            len_b_reg     <= len_b_next;
            ended_reg     <= ended_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            order_reg <= res_order;
            trunc_reg <= res_trunc;
        end
    end

    // String stores
    nosc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (len_a_reg[AW-1:0]),
        .wdata (char_byte),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    nosc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (len_b_reg[AW-1:0]),
        .wdata (char_byte),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    // Compare walk
    nosc_walk #(
        .MAX_LEN (MAX_LEN)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .len_a     (len_a_reg),
        .len_b     (len_b_reg),
        .ovf       (ovf_reg),
        .rd_addr_a (raddr_a),
        .rd_addr_b (raddr_b),
        .rd_data_a (rdata_a),
        .rd_data_b (rdata_b),
        .stat      (stat),
        .res_order (res_order),
        .res_trunc (res_trunc)
    );

    assign out_valid = out_valid_reg;
    assign order     = order_reg;
    assign truncated = trunc_reg;

endmodule

// ===== src/nosc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nosc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/nosc_dacc.sv =====
// Shared decimal accumulator: saturating acc * 10 + digit.
module nosc_dacc
    import nosc_pkg::*;
(
    input  logic [VALUE_W-1:0] acc,
    input  logic [3:0]         digit,
    output logic [VALUE_W-1:0] sum
);

    logic [VALUE_W+3:0] wide;

    // x10 as two shifts and an add, then clamp
    always_comb
    begin
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{VALUE_W{1'b0}}, digit};
        if (wide > {4'b0, VALUE_CAP})
        begin
            sum = VALUE_CAP;
        end
        else
        begin
            sum = wide[VALUE_W-1:0];
        end
    end

endmodule

// ===== src/nosc_walk.sv =====
// Compare sequencer: walks both stores run by run and produces the order result.
module nosc_walk
    import nosc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  walk_ctrl_t                   ctrl,
    input  logic [$clog2(MAX_LEN+1)-1:0] len_a,
    input  logic [$clog2(MAX_LEN+1)-1:0] len_b,
    input  logic                         ovf,
    output logic [$clog2(MAX_LEN)-1:0]   rd_addr_a,
    output logic [$clog2(MAX_LEN)-1:0]   rd_addr_b,
    input  logic [7:0]                   rd_data_a,
    input  logic [7:0]                   rd_data_b,
    output walk_stat_t                   stat,
    output logic [1:0]                   res_order,
    output logic                         res_trunc
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int PW = $clog2(MAX_LEN+1);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_FETCH    = 9'b000000010,
        S_EVAL     = 9'b000000100,
        S_DA_FETCH = 9'b000001000,
        S_DA_EVAL  = 9'b000010000,
        S_DB_FETCH = 9'b000100000,
        S_DB_EVAL  = 9'b001000000,
        S_DCMP     = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [PW-1:0]      ia_reg, ia_next, ib_reg, ib_next;
    logic [PW-1:0]      la_reg, la_next, lb_reg, lb_next;
    cls_t               run_reg, run_next;
    logic [VALUE_W-1:0] va_reg, va_next, vb_reg, vb_next;
    logic [1:0]         order_reg, order_next;
    logic               trunc_reg, trunc_next;

    logic [7:0]         byte_a, byte_b;
    cls_t               cls_a, cls_b;
    logic               in_a, in_b;
    logic               a_lt_b;
    logic [VALUE_W-1:0] acc_in, acc_sum;
    logic [3:0]         dig_in;

    // Read addresses follow the walk pointers; past the end reads as end
    assign rd_addr_a = (ia_reg < la_reg) ? ia_reg[AW-1:0] : '0;
    assign rd_addr_b = (ib_reg < lb_reg) ? ib_reg[AW-1:0] : '0;
    assign byte_a    = (ia_reg < la_reg) ? rd_data_a : 8'h00;
    assign byte_b    = (ib_reg < lb_reg) ? rd_data_b : 8'h00;
    assign cls_a     = class_of(byte_a);
    assign cls_b     = class_of(byte_b);
    assign in_a      = (cls_a == run_reg);
    assign in_b      = (cls_b == run_reg);
    assign a_lt_b    = (byte_a < byte_b);

    // One accumulator shared by both digit walks
    assign acc_in = (state_reg == S_DB_EVAL) ? vb_reg : va_reg;
    assign dig_in = (state_reg == S_DB_EVAL) ? byte_b[3:0] : byte_a[3:0];

    nosc_dacc u_dacc (
        .acc   (acc_in),
        .digit (dig_in),
        .sum   (acc_sum)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        la_next    = la_reg;
        lb_next    = lb_reg;
        run_next   = run_reg;
        va_next    = va_reg;
        vb_next    = vb_reg;
        order_next = order_reg;
        trunc_next = trunc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    la_next    = len_a;
                    lb_next    = len_b;
                    trunc_next = ovf;
                    ia_next    = '0;
                    ib_next    = '0;
                    run_next   = CLS_END;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (run_reg != CLS_END && (in_a || in_b))
                begin
                    // inside a letter or other run
                    if (in_a && in_b)
                    begin
                        if (byte_a != byte_b)
                        begin
                            order_next = a_lt_b ? ORD_LESS : ORD_GREATER;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ia_next    = ia_reg + 1'b1;
                            ib_next    = ib_reg + 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                    else if (in_a)
                    begin
                        order_next = ORD_GREATER;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        order_next = ORD_LESS;
                        state_next = S_DONE;
                    end
                end
                else if (cls_a != cls_b)
                begin
                    // start of a run: class order decides
                    order_next = (cls_a < cls_b) ? ORD_LESS : ORD_GREATER;
                    state_next = S_DONE;
                end
                else if (cls_a == CLS_END)
                begin
                    order_next = ORD_EQUAL;
                    state_next = S_DONE;
                end
                else if (cls_a == CLS_DIGIT)
                begin
                    va_next    = '0;
                    vb_next    = '0;
                    run_next   = CLS_END;
                    state_next = S_DA_FETCH;
                end
                else
                begin
                    run_next = cls_a;
                    if (byte_a != byte_b)
                    begin
                        order_next = a_lt_b ? ORD_LESS : ORD_GREATER;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ia_next    = ia_reg + 1'b1;
                        ib_next    = ib_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            S_DA_FETCH:
            begin
                state_next = S_DA_EVAL;
            end
            S_DA_EVAL:
            begin
                if (cls_a == CLS_DIGIT)
                begin
                    va_next    = acc_sum;
                    ia_next    = ia_reg + 1'b1;
                    state_next = S_DA_FETCH;
                end
                else
                begin
                    state_next = S_DB_FETCH;
                end
            end
            S_DB_FETCH:
            begin
                state_next = S_DB_EVAL;
            end
            S_DB_EVAL:
            begin
                if (cls_b == CLS_DIGIT)
                begin
                    vb_next    = acc_sum;
                    ib_next    = ib_reg + 1'b1;
                    state_next = S_DB_FETCH;
                end
                else
                begin
                    state_next = S_DCMP;
                end
            end
            S_DCMP:
            begin
                if (va_reg != vb_reg)
                begin
                    order_next = (va_reg < vb_reg) ? ORD_LESS : ORD_GREATER;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_DONE:
            begin
                if (ctrl.take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ia_reg    <= '0;
            ib_reg    <= '0;
            la_reg    <= '0;
            lb_reg    <= '0;
            run_reg   <= CLS_END;
        end
        else
        begin
            state_reg <= state_next;
            ia_reg    <= ia_next;
            ib_reg    <= ib_next;
            la_reg    <= la_next;
            lb_reg    <= lb_next;
            run_reg   <= run_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        va_reg    <= va_next;
        vb_reg    <= vb_next;
        order_reg <= order_next;
        trunc_reg <= trunc_next;
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign res_order = order_reg;
    assign res_trunc = trunc_reg;

    // Walk pointers never run past the stored lengths
    a_ptr_a: assert property (@(posedge clk) disable iff (!rst_n) ia_reg <= la_reg)
        else $error("first walk pointer past stored length");
    a_ptr_b: assert property (@(posedge clk) disable iff (!rst_n) ib_reg <= lb_reg)
        else $error("second walk pointer past stored length");
    // A compare starts only from idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == S_IDLE)
        else $error("compare started while busy");
    // A pending result is held until taken, and never encodes -2
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !ctrl.take) |=> (state_reg == S_DONE))
        else $error("result dropped before taken");
    a_done_code: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> res_order != 2'b10)
        else $error("invalid order code");

endmodule
